// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam int TAG_W   = 16;
    localparam int PRIO_W  = 8;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic              req_type;
        logic [TAG_W-1:0]  proc_tag;
        logic [PRIO_W-1:0] prio_value;
    } t_in_item;

    typedef struct packed {
        logic               got_entry;
        logic [TAG_W-1:0]   out_tag;
        logic [PRIO_W-1:0]  out_prio;
        logic               underflow;
        logic               overflow;
        logic [COUNT_W-1:0] entry_count;
        logic [TAG_W-1:0]   tail_tag;
    } t_out_item;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } t_slot;

    typedef struct packed {
        logic gt;       // stored priority strictly above the new one
        logic at_last;  // index is the tail slot
        logic at_zero;  // index is the head slot
    } t_cmp_res;

endpackage

// ===== rtl/spq_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_store
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_store
    import spq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_slot         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_slot         o_rdata
);

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/spq_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cmp
// Shared compare unit: priority order and scan position checks.
// ----------------------------------------------------------------------------
module spq_cmp
    import spq_pkg::*;
#(
    parameter int AW = 4
) (
    input  logic [PRIO_W-1:0] i_slot_prio,
    input  logic [PRIO_W-1:0] i_new_prio,
    input  logic [AW-1:0]     i_idx,
    input  logic [AW-1:0]     i_last_idx,
    output t_cmp_res          o_res
);

    always_comb begin
        o_res.gt      = (i_slot_prio > i_new_prio);
        o_res.at_last = (i_idx == i_last_idx);
        o_res.at_zero = (i_idx == '0);
    end

endmodule

// ===== rtl/stable_priority_queue.sv =====
`timescale 1ns / 1ps
// Sequence: an insert scans tail to head, moving each larger-priority entry back a
//   slot, then writes the head slot if it lands there; a remove scans head to tail,
//   moving entries forward. Each scan step is a memory read then a compare.
// Throughput: one request at a time; the next is taken once the result
//   is issued, and a stalled result holds the block in its final state.
// Reset: synchronous, active low; queue emptied, slot memory left as is.
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded sorted queue, smallest priority first, equal priorities in arrival
// order, served by a sequencer over one slot memory and one compare unit.
// ----------------------------------------------------------------------------
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int PRIO_BITS   = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PRIO_W-1:0] PRIO_MASK =
        (PRIO_BITS >= PRIO_W) ? {PRIO_W{1'b1}} : PRIO_W'((64'd1 << PRIO_BITS) - 64'd1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EV   = 5'b00100,
        S_HEAD = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_req, n_req;
    logic              r_first, n_first;
    t_slot             r_new, n_new;
    logic [TAG_W-1:0]  r_tail, n_tail;
    logic              r_got, n_got;
    logic [TAG_W-1:0]  r_otag, n_otag;
    logic [PRIO_W-1:0] r_oprio, n_oprio;
    logic              r_under, n_under;
    logic              r_over, n_over;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_slot         mem_wdata;
    t_slot         mem_rdata;
    t_cmp_res      cmp;
    logic [AW-1:0] last_idx;
    t_slot         in_slot;

    assign last_idx      = AW'(r_count - CW'(1));
    assign in_slot.tag   = i_in_data.proc_tag;
    assign in_slot.prio  = i_in_data.prio_value & PRIO_MASK;

    spq_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    spq_cmp #(
        .AW (AW)
    ) u_cmp (
        .i_slot_prio (mem_rdata.prio),
        .i_new_prio  (r_new.prio),
        .i_idx       (r_idx),
        .i_last_idx  (last_idx),
        .o_res       (cmp)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_req       = r_req;
        n_first     = r_first;
        n_new       = r_new;
        n_tail      = r_tail;
        n_got       = r_got;
        n_otag      = r_otag;
        n_oprio     = r_oprio;
        n_under     = r_under;
        n_over      = r_over;
        n_out_valid = r_out_valid & i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = r_new;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data.req_type;
                    n_new   = in_slot;
                    n_first = 1'b1;
                    n_got   = 1'b0;
                    n_otag  = '0;
                    n_oprio = '0;
                    n_under = 1'b0;
                    n_over  = 1'b0;
                    if (i_in_data.req_type == REQ_INSERT) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_over  = 1'b1;
                            n_state = S_DONE;
                        end else if (r_count == '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = in_slot;
                            n_tail    = in_slot.tag;
                            n_count   = r_count + CW'(1);
                            n_state   = S_DONE;
                        end else begin
                            n_idx   = last_idx;
                            n_state = S_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_under = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                n_first = 1'b0;
                if (r_req == REQ_INSERT) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx + AW'(1);
                    if (cmp.gt) begin
                        mem_wdata = mem_rdata;
                        if (cmp.at_zero) begin
                            n_state = S_HEAD;
                        end else begin
                            n_idx   = r_idx - AW'(1);
                            n_state = S_RD;
                        end
                    end else begin
                        mem_wdata = r_new;
                        if (r_first) begin
                            n_tail = r_new.tag;
                        end
                        n_count = r_count + CW'(1);
                        n_state = S_DONE;
                    end
                end else begin
                    if (r_first) begin
                        n_got   = 1'b1;
                        n_otag  = mem_rdata.tag;
                        n_oprio = mem_rdata.prio;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_idx - AW'(1);
                        mem_wdata = mem_rdata;
                    end
                    if (cmp.at_last) begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_HEAD: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_new;
                n_count   = r_count + CW'(1);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.got_entry   = r_got;
                    n_out.out_tag     = r_otag;
                    n_out.out_prio    = r_oprio;
                    n_out.underflow   = r_under;
                    n_out.overflow    = r_over;
                    n_out.entry_count = COUNT_W'(r_count);
                    n_out.tail_tag    = (r_count == '0) ? '0 : r_tail;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_req   <= n_req;
        r_first <= n_first;
        r_new   <= n_new;
        r_tail  <= n_tail;
        r_got   <= n_got;
        r_otag  <= n_otag;
        r_oprio <= n_oprio;
        r_under <= n_under;
        r_over  <= n_over;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again before request finished");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.got_entry && o_out_data.underflow))
        else $error("entry returned on underflow");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow)
            |-> (o_out_data.entry_count == COUNT_W'(QUEUE_DEPTH)))
        else $error("overflow flagged with space left");

endmodule
